### rtl/core/kci_pkg.sv
// Shared types and constants of the keyframe curve interpolator.
`timescale 1ns / 1ps
`default_nettype none

package kci_pkg;

    // Default number of fraction bits of the normalized time.
    localparam int FRACTION_BITS_DEF = 16;

    // Interpolation modes as they arrive on the input word.
    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_LINEAR  = 2'd1,
        MODE_HERMITE = 2'd2,
        MODE_BEZIER  = 2'd3
    } mode_t;

    // Per-word side data that travels down the pipeline with the time.
    typedef struct packed {
        logic signed [31:0] v0;
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [31:0] v1;
        mode_t              mode;
        logic               is_int;
        logic               pass_left;
        logic               clamped;
        logic               force_zero;
        logic               force_one;
    } side_t;

endpackage

`default_nettype wire

### rtl/core/kci_div.sv
// Pipelined restoring divider that forms the normalized time, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module kci_div #(
    parameter int F = kci_pkg::FRACTION_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [31:0]       in_rem,
    input  wire logic [31:0]       in_den,
    input  wire kci_pkg::side_t    in_sb,
    output logic                   out_valid,
    output logic [F:0]             out_t,
    output kci_pkg::side_t         out_sb
);

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic           valid_reg [F];
    logic [31:0]    rem_reg   [F];
    logic [31:0]    den_reg   [F];
    logic [F-1:0]   q_reg     [F];
    kci_pkg::side_t sb_reg    [F];

    for (genvar k = 0; k < F; k++) begin : g_stage
        logic           v_prev;
        logic [31:0]    rem_prev;
        logic [31:0]    den_prev;
        logic [F-1:0]   q_prev;
        kci_pkg::side_t sb_prev;
        logic [32:0]    shifted;
        logic [33:0]    diff;
        logic           fits;
        logic [31:0]    rem_next;

        if (k == 0) begin : g_first
            assign v_prev   = in_valid;
            assign rem_prev = in_rem;
            assign den_prev = in_den;
            assign q_prev   = '0;
            assign sb_prev  = in_sb;
        end else begin : g_rest
            assign v_prev   = valid_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign sb_prev  = sb_reg[k-1];
        end

        // Trial subtraction of the divisor from the doubled remainder.
        assign shifted  = {rem_prev, 1'b0};
        assign diff     = {1'b0, shifted} - {2'b00, den_prev};
        assign fits     = ~diff[33];
        assign rem_next = fits ? diff[31:0] : shifted[31:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_prev;
                q_reg[k]   <= {q_prev[F-2:0], fits};
                sb_reg[k]  <= sb_prev;
            end
        end
    end

    // Times outside the interval, and the right end itself, bypass the quotient.
    assign out_valid = valid_reg[F-1];
    assign out_sb    = sb_reg[F-1];
    assign out_t     = sb_reg[F-1].force_one  ? ONE :
                       sb_reg[F-1].force_zero ? '0  : {1'b0, q_reg[F-1]};

endmodule

`default_nettype wire

### rtl/core/kci_basis.sv
// Three-stage unit that turns the normalized time into the four curve weights.
`timescale 1ns / 1ps
`default_nettype none

module kci_basis #(
    parameter int F = kci_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [F:0]            in_t,
    input  wire kci_pkg::side_t        in_sb,
    output logic                       out_valid,
    output logic signed [F+3:0]        out_w0,
    output logic signed [F+3:0]        out_w1,
    output logic signed [F+3:0]        out_w2,
    output logic signed [F+3:0]        out_w3,
    output kci_pkg::side_t             out_sb
);

    localparam int         WW     = F + 4;
    localparam logic [F:0] ONE    = {1'b1, {F{1'b0}}};
    localparam logic [2*F+1:0] HALF_P = (2*F+2)'(1) << (F - 1);

    // Product of two Q1.F values rounded back to Q1.F.
    function automatic logic [F:0] rnd(input logic [F:0] a, input logic [F:0] b);
        logic [2*F+1:0] p;
        p = (2*F+2)'(a) * (2*F+2)'(b) + HALF_P;
        return p[2*F:F];
    endfunction

    function automatic logic signed [WW-1:0] sx(input logic [F:0] a);
        return $signed({3'b000, a});
    endfunction

    logic                  v1_reg, v2_reg, v3_reg;
    kci_pkg::side_t        sb1_reg, sb2_reg, sb3_reg;
    logic [F:0]            t1_reg, u1_reg, t2a_reg, u2a_reg;
    logic [F:0]            t2_reg, u2_reg, tt_reg, t3_reg, u3_reg, tu2_reg, t2u_reg;
    logic signed [WW-1:0]  w0_reg, w1_reg, w2_reg, w3_reg;
    logic signed [WW-1:0]  w0_next, w1_next, w2_next, w3_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Squares first, then the cubes and mixed terms, then the weights.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb1_reg <= in_sb;
            t1_reg  <= in_t;
            u1_reg  <= ONE - in_t;
            t2a_reg <= rnd(in_t, in_t);
            u2a_reg <= rnd(ONE - in_t, ONE - in_t);

            sb2_reg <= sb1_reg;
            t2_reg  <= t1_reg;
            u2_reg  <= u1_reg;
            tt_reg  <= t2a_reg;
            t3_reg  <= rnd(t2a_reg, t1_reg);
            u3_reg  <= rnd(u2a_reg, u1_reg);
            tu2_reg <= rnd(t1_reg, u2a_reg);
            t2u_reg <= rnd(t2a_reg, u1_reg);

            sb3_reg <= sb2_reg;
            w0_reg  <= w0_next;
            w1_reg  <= w1_next;
            w2_reg  <= w2_next;
            w3_reg  <= w3_next;
        end
    end

    // Weights for the left value, left tangent, right tangent and right value.
    always_comb
    begin
        unique case (sb2_reg.mode)
            kci_pkg::MODE_HERMITE:
            begin
                w0_next = (sx(t3_reg) <<< 1) - (sx(tt_reg) + (sx(tt_reg) <<< 1)) + sx(ONE);
                w1_next = sx(t3_reg) - (sx(tt_reg) <<< 1) + sx(t2_reg);
                w2_next = sx(t3_reg) - sx(tt_reg);
                w3_next = (sx(tt_reg) + (sx(tt_reg) <<< 1)) - (sx(t3_reg) <<< 1);
            end
            kci_pkg::MODE_BEZIER:
            begin
                w0_next = sx(u3_reg);
                w1_next = sx(tu2_reg) + (sx(tu2_reg) <<< 1);
                w2_next = sx(t2u_reg) + (sx(t2u_reg) <<< 1);
                w3_next = sx(t3_reg);
            end
            kci_pkg::MODE_LINEAR,
            kci_pkg::MODE_HOLD:
            begin
                w0_next = sx(u2_reg);
                w1_next = '0;
                w2_next = '0;
                w3_next = sx(t2_reg);
            end
        endcase
    end

    assign out_valid = v3_reg;
    assign out_sb    = sb3_reg;
    assign out_w0    = w0_reg;
    assign out_w1    = w1_reg;
    assign out_w2    = w2_reg;
    assign out_w3    = w3_reg;

endmodule

`default_nettype wire

### rtl/core/kci_mac.sv
// Weighted sum of the key values and tangents: products, then a registered adder tree.
`timescale 1ns / 1ps
`default_nettype none

module kci_mac #(
    parameter int F = kci_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [F+3:0]  in_w0,
    input  wire logic signed [F+3:0]  in_w1,
    input  wire logic signed [F+3:0]  in_w2,
    input  wire logic signed [F+3:0]  in_w3,
    input  wire kci_pkg::side_t       in_sb,
    output logic                      out_valid,
    output logic signed [F+37:0]      out_sum,
    output kci_pkg::side_t            out_sb
);

    localparam int PW = 32 + F + 4;
    localparam int SW = PW + 2;

    logic                 v1_reg, v2_reg, v3_reg;
    kci_pkg::side_t       sb1_reg, sb2_reg, sb3_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [SW-1:0] s01_reg, s23_reg, sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // One multiplier per term, then two adder levels.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb1_reg <= in_sb;
            p0_reg  <= PW'(in_sb.v0) * PW'(in_w0);
            p1_reg  <= PW'(in_sb.m0) * PW'(in_w1);
            p2_reg  <= PW'(in_sb.m1) * PW'(in_w2);
            p3_reg  <= PW'(in_sb.v1) * PW'(in_w3);

            sb2_reg <= sb1_reg;
            s01_reg <= SW'(p0_reg) + SW'(p1_reg);
            s23_reg <= SW'(p2_reg) + SW'(p3_reg);

            sb3_reg <= sb2_reg;
            sum_reg <= s01_reg + s23_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_sum   = sum_reg;
    assign out_sb    = sb3_reg;

endmodule

`default_nettype wire

### rtl/core/keyframe_curve_interpolator.sv
// Top level of the keyframe curve interpolator: time setup, pipeline and output buffer.
//
//   Channel  | Handshake                    | Word
//   ---------+------------------------------+------------------------------------------
//   sample   | sample_valid / sample_ready  | times, values, tangents, mode, int flag
//   result   | result_valid / result_ready  | result_value, time_clamped
//
// One word enters per cycle while sample_ready is high; its result passes through the time
// setup register, one divider stage per quotient bit, three weight and three multiply-add
// stages, and the output register.
// Reset clears all valid bits; data registers are not reset.
// A word held at the output is backed by a one-word skid register; while that register
// is full the whole pipeline freezes and sample_ready is low, so nothing is lost or doubled.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_curve_interpolator #(
    parameter int FRACTION_BITS = kci_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire logic [31:0]        sample_time,
    input  wire logic [31:0]        left_time,
    input  wire logic [31:0]        right_time,
    input  wire logic signed [31:0] left_value,
    input  wire logic signed [31:0] left_out_tangent,
    input  wire logic signed [31:0] right_in_tangent,
    input  wire logic signed [31:0] right_value,
    input  wire logic [1:0]         interp_mode,
    input  wire logic               value_is_integer,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic signed [31:0]      result_value,
    output logic                    time_clamped
);

    localparam int F  = FRACTION_BITS;
    localparam int SW = 32 + F + 6;
    localparam int RW = SW - F;
    localparam logic signed [SW-1:0] ONE_M1 = (SW'(1) << F) - SW'(1);
    localparam logic signed [SW-1:0] HALF   = SW'(1) << (F - 1);
    localparam logic signed [RW-1:0] RMAX   = {{(RW-32){1'b0}}, 32'h7fffffff};
    localparam logic signed [RW-1:0] RMIN   = {{(RW-32){1'b1}}, 32'h80000000};

    logic en;

    // Time setup: signed differences, sign normalization, clamp decisions.
    logic signed [33:0] num, den, nn, dn;
    logic               den_zero, below, after;
    kci_pkg::side_t     sb_next;

    always_comb
    begin
        num      = $signed({2'b00, sample_time}) - $signed({2'b00, left_time});
        den      = $signed({2'b00, right_time}) - $signed({2'b00, left_time});
        nn       = den[33] ? -num : num;
        dn       = den[33] ? -den : den;
        den_zero = (den == '0);
        below    = nn[33];
        after    = !below && (nn >= dn);

        sb_next.v0         = left_value;
        sb_next.m0         = left_out_tangent;
        sb_next.m1         = right_in_tangent;
        sb_next.v1         = right_value;
        sb_next.mode       = kci_pkg::mode_t'(interp_mode);
        sb_next.is_int     = value_is_integer;
        sb_next.pass_left  = den_zero || (kci_pkg::mode_t'(interp_mode) == kci_pkg::MODE_HOLD);
        sb_next.clamped    = !den_zero && (below || (nn > dn));
        sb_next.force_zero = below;
        sb_next.force_one  = after;
    end

    logic           v0_reg;
    logic [31:0]    rem0_reg, den0_reg;
    kci_pkg::side_t sb0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg <= nn[31:0];
            den0_reg <= dn[31:0];
            sb0_reg  <= sb_next;
        end
    end

    // Divider, weights and weighted sum.
    logic                div_valid;
    logic [F:0]          div_t;
    kci_pkg::side_t      div_sb;
    logic                bas_valid;
    logic signed [F+3:0] bas_w0, bas_w1, bas_w2, bas_w3;
    kci_pkg::side_t      bas_sb;
    logic                mac_valid;
    logic signed [SW-1:0] mac_sum;
    kci_pkg::side_t      mac_sb;

    kci_div #(.F(F)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .in_rem    (rem0_reg),
        .in_den    (den0_reg),
        .in_sb     (sb0_reg),
        .out_valid (div_valid),
        .out_t     (div_t),
        .out_sb    (div_sb)
    );

    kci_basis #(.F(F)) u_basis (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_t      (div_t),
        .in_sb     (div_sb),
        .out_valid (bas_valid),
        .out_w0    (bas_w0),
        .out_w1    (bas_w1),
        .out_w2    (bas_w2),
        .out_w3    (bas_w3),
        .out_sb    (bas_sb)
    );

    kci_mac #(.F(F)) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (bas_valid),
        .in_w0     (bas_w0),
        .in_w1     (bas_w1),
        .in_w2     (bas_w2),
        .in_w3     (bas_w3),
        .in_sb     (bas_sb),
        .out_valid (mac_valid),
        .out_sum   (mac_sum),
        .out_sb    (mac_sb)
    );

    // Final scaling: truncate toward zero or round half up, then saturate; pass-left words take the left value.
    logic signed [SW-1:0] adj;
    logic signed [RW-1:0] rq;
    logic signed [31:0]   value_next;

    always_comb
    begin
        if (mac_sb.is_int)
        begin
            adj = mac_sum[SW-1] ? mac_sum + ONE_M1 : mac_sum;
        end
        else
        begin
            adj = mac_sum + HALF;
        end
        rq = adj[SW-1:F];
        priority if (mac_sb.pass_left)
        begin
            value_next = mac_sb.v0;
        end
        else if (rq > RMAX)
        begin
            value_next = RMAX[31:0];
        end
        else if (rq < RMIN)
        begin
            value_next = RMIN[31:0];
        end
        else
        begin
            value_next = rq[31:0];
        end
    end

    // Output register with a one-word skid register behind it.
    logic               out_valid_reg, skid_valid_reg;
    logic signed [31:0] out_value_reg, skid_value_reg;
    logic               out_clamp_reg, skid_clamp_reg;
    logic               take, push;

    assign en   = !skid_valid_reg;
    assign take = out_valid_reg && result_ready;
    assign push = en && mac_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_value_reg <= skid_value_reg;
                out_clamp_reg <= skid_clamp_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_value_reg <= value_next;
                skid_clamp_reg <= mac_sb.clamped;
            end
            else
            begin
                out_value_reg <= value_next;
                out_clamp_reg <= mac_sb.clamped;
            end
        end
    end

    assign sample_ready = en;
    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;
    assign time_clamped = out_clamp_reg;

`ifndef ASSERT_OFF
    // The skid register only fills behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word present without an output word");

    // A finished word that meets a stalled output is parked, not dropped.
    a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !result_ready) |=> skid_valid_reg)
        else $error("finished word lost while output stalled");

    // Taking the output moves the skid word into the output register and empties the skid register.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && take) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid word not moved to output");

    // The pipeline is frozen while the skid register is full.
    a_freeze_input: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> (!sample_ready && !push))
        else $error("pipeline advanced with skid full");
`endif

endmodule

`default_nettype wire

### sim/tb_keyframe_curve_interpolator.sv
// Self-checking testbench of the keyframe curve interpolator: driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_keyframe_curve_interpolator;

    localparam int FB = kci_pkg::FRACTION_BITS_DEF;
    localparam longint ONE_Q = 64'sd1 << FB;
    localparam longint HALF_Q = 64'sd1 << (FB - 1);
    localparam int LATENCY = FB + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    // One segment word as it is offered on the sample channel.
    typedef struct {
        logic [31:0]        ts;
        logic [31:0]        tl;
        logic [31:0]        tr;
        logic signed [31:0] v0;
        logic signed [31:0] m0;
        logic signed [31:0] m1;
        logic signed [31:0] v1;
        kci_pkg::mode_t     mode;
        logic               is_int;
    } segment_t;

    // One expected result word.
    typedef struct {
        logic signed [31:0] value;
        logic               clamped;
    } curve_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    logic [31:0] sample_time = '0;
    logic [31:0] left_time = '0;
    logic [31:0] right_time = '0;
    logic signed [31:0] left_value = '0;
    logic signed [31:0] left_out_tangent = '0;
    logic signed [31:0] right_in_tangent = '0;
    logic signed [31:0] right_value = '0;
    logic [1:0] interp_mode = '0;
    logic value_is_integer = 1'b0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic signed [31:0] result_value;
    logic time_clamped;

    segment_t     pending_segments[$];
    curve_point_t expected_points[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  error_count = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  quiet_cycles = 0;

    keyframe_curve_interpolator u_dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready),
        .sample_time(sample_time), .left_time(left_time), .right_time(right_time),
        .left_value(left_value), .left_out_tangent(left_out_tangent),
        .right_in_tangent(right_in_tangent), .right_value(right_value),
        .interp_mode(interp_mode), .value_is_integer(value_is_integer),
        .result_valid(result_valid), .result_ready(result_ready),
        .result_value(result_value), .time_clamped(time_clamped)
    );

    always #5 clk = ~clk;

    // Rounded product of two nonnegative Q1.F factors.
    function automatic longint q_mul(longint a, longint b);
        return (a * b + HALF_Q) >>> FB;
    endfunction

    // Computes the interpolated value and clamp flag of one segment.
    function automatic curve_point_t eval_curve(segment_t s);
        curve_point_t p;
        longint num, den, t, t2, t3, u, u2, u3, acc, r;
        longint v0, m0, m1, v1;
        num = longint'(s.ts) - longint'(s.tl);
        den = longint'(s.tr) - longint'(s.tl);
        v0 = s.v0; m0 = s.m0; m1 = s.m1; v1 = s.v1;
        p.clamped = 1'b0;
        p.value = s.v0;
        if (den == 0)
            return p;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        if (num < 0)
        begin
            t = 0;
            p.clamped = 1'b1;
        end
        else if (num >= den)
        begin
            t = ONE_Q;
            p.clamped = (num > den);
        end
        else
            t = (num << FB) / den;
        if (s.mode == kci_pkg::MODE_HOLD)
            return p;
        t2 = q_mul(t, t);
        t3 = q_mul(t2, t);
        u = ONE_Q - t;
        u2 = q_mul(u, u);
        u3 = q_mul(u2, u);
        case (s.mode)
            kci_pkg::MODE_LINEAR:  acc = v0 * (ONE_Q - t) + v1 * t;
            kci_pkg::MODE_HERMITE: acc = v0 * (2 * t3 - 3 * t2 + ONE_Q)
                                       + m0 * (t3 - 2 * t2 + t)
                                       + m1 * (t3 - t2) + v1 * (3 * t2 - 2 * t3);
            default:               acc = v0 * u3 + m0 * (3 * q_mul(t, u2))
                                       + m1 * (3 * q_mul(t2, u)) + v1 * t3;
        endcase
        // Integer values truncate toward zero; fixed-point values round half up.
        if (s.is_int)
            r = acc / ONE_Q;
        else
            r = (acc + HALF_Q) >>> FB;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        p.value = r[31:0];
        return p;
    endfunction

    // Biased 32-bit value: often an extreme, sometimes a small value up to 4 << 16 in magnitude, else fully random.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4: return $urandom_range(0, 1) ? $urandom_range(0, 4 << 16)
                                           : -$urandom_range(0, 4 << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic segment_t rand_segment();
        segment_t s;
        logic [31:0] base, span;
        base = $urandom;
        span = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(1, 5000);
        s.tl = base;
        s.tr = base + span;
        case ($urandom_range(0, 9))
            0: s.ts = s.tl - $urandom_range(1, 100);
            1: s.ts = s.tr + $urandom_range(1, 100);
            2: s.ts = s.tl;
            3: s.ts = s.tr;
            4:
            begin
                s.tr = s.tl;
                s.ts = $urandom;
            end
            5: s.ts = $urandom;
            default: s.ts = s.tl + $urandom_range(0, span);
        endcase
        // Swapped keys now and then.
        if ($urandom_range(0, 7) == 0)
        begin
            s.tl = s.tr;
            s.tr = base;
        end
        s.v0 = rand_word();
        s.m0 = rand_word();
        s.m1 = rand_word();
        s.v1 = rand_word();
        s.mode = kci_pkg::mode_t'($urandom_range(0, 3));
        s.is_int = $urandom_range(0, 1);
        return s;
    endfunction

    function automatic segment_t make_segment(logic [31:0] ts, logic [31:0] tl,
                                              logic [31:0] tr, logic [31:0] v0,
                                              logic [31:0] m0, logic [31:0] m1,
                                              logic [31:0] v1, kci_pkg::mode_t mode,
                                              logic is_int);
        segment_t s;
        s.ts = ts; s.tl = tl; s.tr = tr;
        s.v0 = v0; s.m0 = m0; s.m1 = m1; s.v1 = v1;
        s.mode = mode; s.is_int = is_int;
        return s;
    endfunction

    // Driver: offers queued words, keeps valid and payload until accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                words_in <= words_in + 1;
            if (!sample_valid || sample_ready)
            begin
                if (pending_segments.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    segment_t s;
                    s = pending_segments.pop_front();
                    expected_points.push_back(eval_curve(s));
                    sample_valid <= 1'b1;
                    sample_time <= s.ts;
                    left_time <= s.tl;
                    right_time <= s.tr;
                    left_value <= s.v0;
                    left_out_tangent <= s.m0;
                    right_in_tangent <= s.m1;
                    right_value <= s.v1;
                    interp_mode <= s.mode;
                    value_is_integer <= s.is_int;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result word and drives the receiver stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if ((result_valid && result_ready) || (sample_valid && sample_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (result_valid && result_ready)
            begin
                words_out <= words_out + 1;
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result word: value %0d clamped %0b",
                           result_value, time_clamped);
                    error_count++;
                end
                else
                begin
                    curve_point_t e;
                    e = expected_points.pop_front();
                    if (result_value !== e.value)
                    begin
                        $error("result_value: expected %0d, got %0d", e.value, result_value);
                        error_count++;
                    end
                    if (time_clamped !== e.clamped)
                    begin
                        $error("time_clamped: expected %0b, got %0b", e.clamped, time_clamped);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_points.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus phases and end of run.
    initial
    begin
        int phase_idle[4];
        int phase_stall[4];
        phase_idle = '{0, 54, 0, 27};
        phase_stall = '{0, 0, 54, 27};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every mode, clamps, endpoints, equal and swapped keys.
        for (int m = 0; m < 4; m++)
        begin
            pending_segments.push_back(make_segment(50, 100, 200, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, kci_pkg::mode_t'(m), 1'b0));
            pending_segments.push_back(make_segment(300, 100, 200, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, kci_pkg::mode_t'(m), 1'b1));
            pending_segments.push_back(make_segment(150, 200, 100, -(3 << 16),
                5 << 16, -(7 << 16), 11 << 16, kci_pkg::mode_t'(m), 1'b0));
            pending_segments.push_back(make_segment(133, 100, 200, -7, 13, -5, 9,
                kci_pkg::mode_t'(m), 1'b1));
            pending_segments.push_back(make_segment(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF, kci_pkg::mode_t'(m), 1'b0));
        end
        pending_segments.push_back(make_segment(7, 100, 100, 32'h1234_5678, 0, 0, 1,
            kci_pkg::MODE_BEZIER, 1'b0));
        pending_segments.push_back(make_segment(100, 100, 200, -1, 3, 3, -1,
            kci_pkg::MODE_LINEAR, 1'b1));
        pending_segments.push_back(make_segment(0, 32'hFFFF_FFFF, 0, 1 << 16, 0, 0,
            -(1 << 16), kci_pkg::MODE_HERMITE, 1'b0));

        // Random phases, each with its own sender and receiver pacing.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int i = 0; i < 256; i++)
                pending_segments.push_back(rand_segment());
            wait (pending_segments.size() == 0 && expected_points.size() == 0);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2 * LATENCY) @(posedge clk);

        $display("Checked %0d segment words in hold, linear, hermite and bezier modes,",
                 words_out);
        $display("with clamped, endpoint, equal-key and swapped-key times under mixed pacing.");
        if (error_count == 0 && expected_points.size() == 0 && words_in == words_out)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/kci_pkg.sv
rtl/core/kci_div.sv
rtl/core/kci_basis.sv
rtl/core/kci_mac.sv
rtl/core/keyframe_curve_interpolator.sv
sim/tb_keyframe_curve_interpolator.sv
